// ===== hw/rtl/biquad_iir_filter_multichannel_top_assert.svh =====
// Assertion macros used by the multichannel biquad filter top level.
`ifndef BIQUAD_IIR_FILTER_MULTICHANNEL_TOP_ASSERT_SVH
`define BIQUAD_IIR_FILTER_MULTICHANNEL_TOP_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define BQF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bqf: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define BQF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bqf: next-cycle check failed");
`endif

// ===== hw/rtl/bqf_pkg.sv =====
// Shared constants and types for the multichannel biquad filter.
package bqf_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SMP_W = 16;
  localparam int COEF_W = 32;
  localparam int Y_W = 40;
  localparam int FRAC_SH = 28;
  localparam int ACC_W = 76;
  localparam int IDX_W = 3;
  localparam int NCH_W = 4;
  localparam int CNT_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_B0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NCH = 3'd5;

  localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh1000_0000;
  localparam logic [NCH_W-1:0] NCH_RESET = 4'd1;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } bqf_coef_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] x1;
    logic signed [SMP_W-1:0] x2;
    logic signed [Y_W-1:0]   y1;
    logic signed [Y_W-1:0]   y2;
  } bqf_hist_t;

endpackage

// ===== hw/rtl/biquad_iir_filter_multichannel_top.sv =====
// A word is registered in s1, then in the output register. While out_ready is
// high: one word per cycle, also when consecutive words share a channel.
// History read and MAC are combinational in s1; the history write is registered.
// Reset (synchronous, active low) sets b0 to 1.0, the other taps to zero,
// one channel, all history to zero and the channel counter to zero.
module biquad_iir_filter_multichannel_top import bqf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [SMP_W-1:0]  in_sample_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SMP_W-1:0]  out_sample_out,
  output logic [IDX_W-1:0]         out_channel_index,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]        cfg_data
);

  bqf_coef_t               coef_r;
  logic [NCH_W-1:0]        nch_r;
  logic                    s1_v_r;
  logic signed [SMP_W-1:0] s1_x_r;
  logic [CH_W-1:0]         s1_ch_r;
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_sample_r;
  logic [IDX_W-1:0]        out_ch_r;
  logic                    out_adv;
  logic                    s1_adv;
  logic                    in_acc;
  logic [CH_W-1:0]         new_ch;
  bqf_hist_t               hist;
  logic signed [Y_W-1:0]   y0;
  logic signed [SMP_W-1:0] sample;

  assign cfg_ready = 1'b1;
  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv = s1_v_r && out_adv;
  assign in_ready = !s1_v_r || out_adv;
  assign in_acc = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_channel_index = out_ch_r;

  bqf_chan_seq u_chan_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (in_acc),
    .num_channels (nch_r),
    .ch           (new_ch)
  );

  bqf_history u_history (
    .clk   (clk),
    .rst_n (rst_n),
    .ch    (s1_ch_r),
    .wr_en (s1_adv),
    .x0    (s1_x_r),
    .y0    (y0),
    .hist  (hist)
  );

  bqf_mac u_mac (
    .coef   (coef_r),
    .hist   (hist),
    .x0     (s1_x_r),
    .y0     (y0),
    .sample (sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= B0_RESET;
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
      nch_r <= NCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_B0:  coef_r.b0 <= $signed(cfg_data);
        CFG_B1:  coef_r.b1 <= $signed(cfg_data);
        CFG_B2:  coef_r.b2 <= $signed(cfg_data);
        CFG_A1:  coef_r.a1 <= $signed(cfg_data);
        CFG_A2:  coef_r.a2 <= $signed(cfg_data);
        CFG_NCH: nch_r <= cfg_data[NCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r <= in_sample_in;
      s1_ch_r <= new_ch;
    end
    if (s1_adv) begin
      out_sample_r <= sample;
      out_ch_r <= IDX_W'(s1_ch_r);
    end
  end

`include "biquad_iir_filter_multichannel_top_assert.svh"

  `BQF_ASSERT_NEXT(a_s1_hold, s1_v_r && !out_adv, s1_v_r && $stable(s1_ch_r) && $stable(s1_x_r))
  `BQF_ASSERT_NEXT(a_s1_to_out, s1_adv, out_valid_r)
  `BQF_ASSERT_SAME(a_no_overrun, in_acc && s1_v_r, s1_adv)

endmodule

// ===== hw/rtl/bqf_chan_seq.sv =====
// Channel counter that assigns each incoming word to its channel.
module bqf_chan_seq import bqf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [NCH_W-1:0] num_channels,
  output logic [CH_W-1:0]  ch
);

  logic [CH_W-1:0]  cnt_r;
  logic [CH_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0] eff;
  logic [CNT_W-1:0] ch_inc;

  always_comb begin
    if (num_channels == '0) begin
      eff = CNT_W'(1);
    end else if (CNT_W'(num_channels) > CNT_W'(MAX_CHANNELS)) begin
      eff = CNT_W'(MAX_CHANNELS);
    end else begin
      eff = CNT_W'(num_channels);
    end
    ch = (CNT_W'(cnt_r) >= eff) ? '0 : cnt_r;
    ch_inc = CNT_W'(ch) + CNT_W'(1);
    cnt_nxt = (ch_inc >= eff) ? '0 : CH_W'(ch_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/bqf_history.sv =====
// Per-channel storage of the two previous inputs and two previous outputs.
module bqf_history import bqf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CH_W-1:0]         ch,
  input  logic                    wr_en,
  input  logic signed [SMP_W-1:0] x0,
  input  logic signed [Y_W-1:0]   y0,
  output bqf_hist_t               hist
);

  logic signed [SMP_W-1:0] x1_r [MAX_CHANNELS];
  logic signed [SMP_W-1:0] x2_r [MAX_CHANNELS];
  logic signed [Y_W-1:0]   y1_r [MAX_CHANNELS];
  logic signed [Y_W-1:0]   y2_r [MAX_CHANNELS];

  always_comb begin
    hist.x1 = x1_r[ch];
    hist.x2 = x2_r[ch];
    hist.y1 = y1_r[ch];
    hist.y2 = y2_r[ch];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
    end else if (wr_en) begin
      x2_r[ch] <= hist.x1;
      x1_r[ch] <= x0;
      y2_r[ch] <= hist.y1;
      y1_r[ch] <= y0;
    end
  end

endmodule

// ===== hw/rtl/bqf_mac.sv =====
// Biquad multiply-accumulate with output history saturation and int16 truncation.
module bqf_mac import bqf_pkg::*; (
  input  bqf_coef_t               coef,
  input  bqf_hist_t               hist,
  input  logic signed [SMP_W-1:0] x0,
  output logic signed [Y_W-1:0]   y0,
  output logic signed [SMP_W-1:0] sample
);

  localparam int PB_W  = SMP_W + COEF_W;
  localparam int FF_W  = PB_W + 2;
  localparam int YH_W  = Y_W - 8;
  localparam int PAH_W = COEF_W + YH_W;
  localparam int PAL_W = COEF_W + 9;
  localparam int TOP   = FRAC_SH + Y_W - 1;

  logic signed [PB_W-1:0]  p_b0;
  logic signed [PB_W-1:0]  p_b1;
  logic signed [PB_W-1:0]  p_b2;
  logic signed [FF_W-1:0]  ff;
  logic signed [YH_W-1:0]  y1h;
  logic signed [YH_W-1:0]  y2h;
  logic signed [8:0]       y1l;
  logic signed [8:0]       y2l;
  logic signed [PAH_W-1:0] p_a1h;
  logic signed [PAH_W-1:0] p_a2h;
  logic signed [PAL_W-1:0] p_a1l;
  logic signed [PAL_W-1:0] p_a2l;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1-TOP:0]    acc_top;
  logic signed [YH_W-1:0]  yq;

  always_comb begin
    p_b0 = $signed(coef.b0) * $signed(x0);
    p_b1 = $signed(coef.b1) * $signed(hist.x1);
    p_b2 = $signed(coef.b2) * $signed(hist.x2);
    ff = FF_W'(p_b0) + FF_W'(p_b1) + FF_W'(p_b2);

    // Each feedback term splits y into an integer part and an 8-bit fraction.
    y1h = YH_W'($signed(hist.y1) >>> 8);
    y2h = YH_W'($signed(hist.y2) >>> 8);
    y1l = $signed({1'b0, hist.y1[7:0]});
    y2l = $signed({1'b0, hist.y2[7:0]});
    p_a1h = $signed(coef.a1) * y1h;
    p_a2h = $signed(coef.a2) * y2h;
    p_a1l = $signed(coef.a1) * y1l;
    p_a2l = $signed(coef.a2) * y2l;

    acc = (ACC_W'(ff) <<< 8) - (ACC_W'(p_a1h) <<< 8) - ACC_W'(p_a1l)
        - (ACC_W'(p_a2h) <<< 8) - ACC_W'(p_a2l);

    acc_top = acc[ACC_W-1:TOP];
    if ((&acc_top) || !(|acc_top)) begin
      y0 = acc[TOP:FRAC_SH];
    end else begin
      y0 = acc[ACC_W-1] ? Y_MIN : Y_MAX;
    end

    // Truncate toward zero, then clamp to the 16-bit range.
    yq = YH_W'(y0 >>> 8);
    if (y0[Y_W-1] && (y0[7:0] != 8'd0)) begin
      yq = yq + YH_W'(1);
    end
    if (yq > YH_W'(SMP_MAX)) begin
      sample = SMP_MAX;
    end else if (yq < YH_W'(SMP_MIN)) begin
      sample = SMP_MIN;
    end else begin
      sample = yq[SMP_W-1:0];
    end
  end

endmodule
